[rtl/bmm_pkg.sv]
// Shared constants, types and helper functions for the blocked matrix multiply.
package bmm_pkg;

    localparam int TILE     = 8;
    localparam int BLOCKS   = 4;
    localparam int SIDE     = TILE * BLOCKS;
    localparam int ADDR_W   = $clog2(SIDE * SIDE);
    localparam int DEPTH    = SIDE * SIDE;
    localparam int IDX_W    = 5;
    localparam int NB_W     = 3;
    localparam int N_W      = $clog2(SIDE + 1);
    localparam int TILE_W   = (TILE > 1) ? $clog2(TILE) : 1;
    localparam int BLK_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef enum logic [1:0] {
        FN_WR_A    = 2'd0,
        FN_WR_B    = 2'd1,
        FN_COMPUTE = 2'd2,
        FN_RD_C    = 2'd3
    } func_t;

    typedef struct packed {
        func_t               op;
        logic                err;
        logic [ADDR_W-1:0]   addr;
        logic [31:0]         data;
        logic [NB_W-1:0]     nb;
    } cmd_t;

    // Unrounded float: value = sig / 2^47 * 2^(exp - 127)
    typedef struct packed {
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        sig;
        logic               special;
        logic [31:0]        spec_val;
    } pre_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_MUL,
        ST_MULW,
        ST_ADDW,
        ST_CRD,
        ST_CADD,
        ST_CWAIT,
        ST_READ,
        ST_RESP
    } state_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int b = 47; b >= 0; b--) begin
            if (!found && v[b]) begin
                n     = 6'(47 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/bmm_queue.sv]
// Two-entry command queue between the front end and the execution engine.
module bmm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bmm_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bmm_pkg::cmd_t pop_cmd
);
    import bmm_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/bmm_front.sv]
// Front end: config register, item decode, range check and queue push.
module bmm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[1:0], row_index[6:2], col_index[11:7], element_value[43:12]
    input  logic [bmm_pkg::IN_W-1:0]       s_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bmm_pkg::NB_W-1:0]       cfg_data,
    output logic                           push_valid,
    input  logic                           push_ready,
    output bmm_pkg::cmd_t                  push_cmd
);
    import bmm_pkg::*;

    logic [NB_W-1:0]  blocks_used_reg;
    logic [NB_W-1:0]  nb;
    logic [N_W-1:0]   n_active;
    logic [IDX_W-1:0] row, col;
    func_t            op;

    assign cfg_ready  = 1'b1;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_used_reg <= NB_W'(BLOCKS);
        end else if (cfg_valid) begin
            blocks_used_reg <= cfg_data;
        end
    end

    always_comb begin
        op  = func_t'(s_tdata[1:0]);
        row = s_tdata[6:2];
        col = s_tdata[11:7];
        if (blocks_used_reg == '0) begin
            nb = NB_W'(1);
        end else if (blocks_used_reg > NB_W'(BLOCKS)) begin
            nb = NB_W'(BLOCKS);
        end else begin
            nb = blocks_used_reg;
        end
        n_active      = N_W'(int'(nb) * TILE);
        push_cmd.op   = op;
        push_cmd.err  = (op != FN_COMPUTE) &&
                        ((N_W'(row) >= n_active) || (N_W'(col) >= n_active));
        push_cmd.addr = ADDR_W'(int'(row) * SIDE + int'(col));
        push_cmd.data = s_tdata[43:12];
        push_cmd.nb   = nb;
    end

endmodule

[rtl/bmm_norm.sv]
// Two-stage normalize and round-to-nearest-even to binary32.
module bmm_norm (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          valid_i,
    input  bmm_pkg::pre_t pre_i,
    output logic          valid_o,
    output logic [31:0]   res_o
);
    import bmm_pkg::*;

    logic               v1_reg, v2_reg;
    pre_t               p1_reg;
    logic [5:0]         lz1_reg;
    logic [31:0]        res_reg;

    logic signed [10:0] em1, sh, rs, ef;
    logic [47:0]        sig_sh;
    logic               rsticky, g, st, inc;
    logic [7:0]         exp_pre;
    logic [30:0]        packed_val;
    logic [31:0]        res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg  <= pre_i;
        lz1_reg <= lzc48(pre_i.sig);
        res_reg <= res_next;
    end

    always_comb begin
        em1     = p1_reg.exp - 11'sd1;
        sh      = (signed'({5'b0, lz1_reg}) <= em1) ? signed'({5'b0, lz1_reg}) : em1;
        rs      = -sh;
        sig_sh  = '0;
        rsticky = 1'b0;
        if (sh >= 0) begin
            sig_sh = p1_reg.sig << sh[5:0];
        end else if (rs >= 11'sd48) begin
            rsticky = |p1_reg.sig;
        end else begin
            sig_sh  = p1_reg.sig >> rs[5:0];
            rsticky = |(p1_reg.sig & ~({48{1'b1}} << rs[5:0]));
        end
        ef         = p1_reg.exp - sh;
        g          = sig_sh[23];
        st         = (|sig_sh[22:0]) | rsticky;
        inc        = g && (st || sig_sh[24]);
        exp_pre    = sig_sh[47] ? ef[7:0] : 8'd0;
        packed_val = {exp_pre, sig_sh[46:24]} + 31'(inc);
        if (p1_reg.special) begin
            res_next = p1_reg.spec_val;
        end else if (p1_reg.sig == '0) begin
            res_next = {p1_reg.sign, 31'd0};
        end else if (sig_sh[47] && (ef >= 11'sd255)) begin
            res_next = {p1_reg.sign, 8'hFF, 23'd0};
        end else begin
            res_next = {p1_reg.sign, packed_val};
        end
    end

    assign valid_o = v2_reg;
    assign res_o   = res_reg;

endmodule

[rtl/bmm_fmul.sv]
// Binary32 multiplier: unpack and 24x24 product, then normalize and round.
module bmm_fmul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        valid_i,
    input  logic [31:0] a_i,
    input  logic [31:0] b_i,
    output logic        valid_o,
    output logic [31:0] res_o
);
    import bmm_pkg::*;

    logic        v0_reg;
    pre_t        p0_reg, p0_next;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;

    always_comb begin
        ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
        eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
        ma     = {a_i[30:23] != 8'd0, a_i[22:0]};
        mb     = {b_i[30:23] != 8'd0, b_i[22:0]};
        a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
        b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
        a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == '0);
        b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == '0);
        a_zero = (a_i[30:0] == '0);
        b_zero = (b_i[30:0] == '0);
        sgn    = a_i[31] ^ b_i[31];
        p0_next.sign     = sgn;
        p0_next.exp      = signed'({3'b0, ea}) + signed'({3'b0, eb}) - 11'sd126;
        p0_next.sig      = ma * mb;
        p0_next.special  = a_nan || b_nan || a_inf || b_inf;
        if (a_nan) begin
            p0_next.spec_val = a_i | QUIET_BIT;
        end else if (b_nan) begin
            p0_next.spec_val = b_i | QUIET_BIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            p0_next.spec_val = QNAN_DEFAULT;
        end else begin
            p0_next.spec_val = {sgn, 8'hFF, 23'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else begin
            v0_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg <= p0_next;
    end

    bmm_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (v0_reg),
        .pre_i   (p0_reg),
        .valid_o (valid_o),
        .res_o   (res_o)
    );

endmodule

[rtl/bmm_fadd.sv]
// Binary32 adder: swap and align, add, then normalize and round.
module bmm_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        valid_i,
    input  logic [31:0] x_i,
    input  logic [31:0] y_i,
    output logic        valid_o,
    output logic [31:0] res_o
);
    import bmm_pkg::*;

    logic        v0_reg, v1_reg;
    logic        sb_reg, sx_reg, sy_reg, sub_reg, spec_reg;
    logic [7:0]  eb_reg;
    logic [26:0] mb_reg, ms_reg;
    logic [31:0] specv_reg;
    pre_t        p1_reg, p1_next;

    logic [31:0] big, sml, specv_next;
    logic [7:0]  eb, es, d;
    logic [26:0] mb27, ms27, al;
    logic        x_nan, y_nan, x_inf, y_inf, spec_next, al_st;
    logic [27:0] sum;

    always_comb begin
        x_nan = (x_i[30:23] == 8'hFF) && (x_i[22:0] != '0);
        y_nan = (y_i[30:23] == 8'hFF) && (y_i[22:0] != '0);
        x_inf = (x_i[30:23] == 8'hFF) && (x_i[22:0] == '0);
        y_inf = (y_i[30:23] == 8'hFF) && (y_i[22:0] == '0);
        spec_next = x_nan || y_nan || x_inf || y_inf;
        if (x_nan) begin
            specv_next = x_i | QUIET_BIT;
        end else if (y_nan) begin
            specv_next = y_i | QUIET_BIT;
        end else if (x_inf && y_inf && (x_i[31] != y_i[31])) begin
            specv_next = QNAN_DEFAULT;
        end else if (x_inf) begin
            specv_next = x_i;
        end else begin
            specv_next = y_i;
        end
        big   = (x_i[30:0] >= y_i[30:0]) ? x_i : y_i;
        sml   = (x_i[30:0] >= y_i[30:0]) ? y_i : x_i;
        eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = eb - es;
        mb27  = {big[30:23] != 8'd0, big[22:0], 3'b000};
        ms27  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        if (d >= 8'd27) begin
            al    = '0;
            al_st = |ms27;
        end else begin
            al    = ms27 >> d[4:0];
            al_st = |(ms27 & ~({27{1'b1}} << d[4:0]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= valid_i;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sb_reg    <= big[31];
        sx_reg    <= x_i[31];
        sy_reg    <= y_i[31];
        sub_reg   <= big[31] ^ sml[31];
        spec_reg  <= spec_next;
        specv_reg <= specv_next;
        eb_reg    <= eb;
        mb_reg    <= mb27;
        ms_reg    <= al | 27'(al_st);
        p1_reg    <= p1_next;
    end

    always_comb begin
        sum = sub_reg ? ({1'b0, mb_reg} - {1'b0, ms_reg}) : ({1'b0, mb_reg} + {1'b0, ms_reg});
        p1_next.sign     = (sum == '0) ? (sx_reg & sy_reg) : sb_reg;
        p1_next.exp      = signed'({3'b0, eb_reg}) + 11'sd1;
        p1_next.sig      = {sum, 20'd0};
        p1_next.special  = spec_reg;
        p1_next.spec_val = specv_reg;
    end

    bmm_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (v1_reg),
        .pre_i   (p1_reg),
        .valid_o (valid_o),
        .res_o   (res_o)
    );

endmodule

[rtl/bmm_back.sv]
// Execution engine: A/B/C stores, tiled multiply sequencer and result register.
module bmm_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  bmm_pkg::cmd_t              cmd,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_value[31:0], status[32]
    output logic [bmm_pkg::OUT_W-1:0]  m_tdata
);
    import bmm_pkg::*;

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];
    logic [31:0] mem_c [DEPTH];
    logic [31:0] a_q_reg, b_q_reg, c_q_reg;

    state_t            state_reg, state_next;
    logic              c_live_reg, c_live_next;
    logic [NB_W-1:0]   nb_reg, nb_next;
    logic [BLK_W-1:0]  bi_reg, bj_reg, bk_reg, bi_next, bj_next, bk_next;
    logic [TILE_W-1:0] i_reg, j_reg, k_reg, i_next, j_next, k_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       resp_val_reg, resp_val_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_val_reg, out_val_next;
    logic              out_st_reg, out_st_next;

    logic              out_free;
    logic [ADDR_W-1:0] a_raddr, b_raddr, c_raddr, c_idx, c_waddr;
    logic              a_we, b_we, c_we;
    logic [31:0]       c_wdata;
    logic              mul_v_in, mul_v_out, add_v_in, add_v_out;
    logic [31:0]       mul_res, add_x, add_y, add_res;
    logic [BLK_W-1:0]  blk_last;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_st_reg, out_val_reg};
    assign blk_last = BLK_W'(int'(nb_reg) - 1);

    assign a_raddr = ADDR_W'((int'(bi_reg) * TILE + int'(i_reg)) * SIDE +
                             int'(bk_reg) * TILE + int'(k_reg));
    assign b_raddr = ADDR_W'((int'(bk_reg) * TILE + int'(k_reg)) * SIDE +
                             int'(bj_reg) * TILE + int'(j_reg));
    assign c_idx   = ADDR_W'((int'(bi_reg) * TILE + int'(i_reg)) * SIDE +
                             int'(bj_reg) * TILE + int'(j_reg));
    assign c_raddr = (state_reg == ST_IDLE) ? cmd.addr : c_idx;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            mem_a[cmd.addr] <= cmd.data;
        end
        if (b_we) begin
            mem_b[cmd.addr] <= cmd.data;
        end
        if (c_we) begin
            mem_c[c_waddr] <= c_wdata;
        end
        a_q_reg <= mem_a[a_raddr];
        b_q_reg <= mem_b[b_raddr];
        c_q_reg <= mem_c[c_raddr];
    end

    bmm_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (mul_v_in),
        .a_i     (a_q_reg),
        .b_i     (b_q_reg),
        .valid_o (mul_v_out),
        .res_o   (mul_res)
    );

    bmm_fadd u_fadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (add_v_in),
        .x_i     (add_x),
        .y_i     (add_y),
        .valid_o (add_v_out),
        .res_o   (add_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            c_live_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            c_live_reg    <= c_live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nb_reg       <= nb_next;
        bi_reg       <= bi_next;
        bj_reg       <= bj_next;
        bk_reg       <= bk_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        clr_reg      <= clr_next;
        acc_reg      <= acc_next;
        resp_val_reg <= resp_val_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
    end

    always_comb begin
        state_next     = state_reg;
        c_live_next    = c_live_reg;
        nb_next        = nb_reg;
        bi_next        = bi_reg;
        bj_next        = bj_reg;
        bk_next        = bk_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        acc_next       = acc_reg;
        resp_val_next  = resp_val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        cmd_ready      = 1'b0;
        a_we           = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        c_waddr        = c_idx;
        c_wdata        = add_res;
        mul_v_in       = 1'b0;
        add_v_in       = 1'b0;
        add_x          = acc_reg;
        add_y          = mul_res;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    if (cmd.err) begin
                        out_valid_next = 1'b1;
                        out_val_next   = '0;
                        out_st_next    = 1'b1;
                    end else begin
                        unique case (cmd.op)
                            FN_WR_A, FN_WR_B: begin
                                a_we           = (cmd.op == FN_WR_A);
                                b_we           = (cmd.op == FN_WR_B);
                                out_valid_next = 1'b1;
                                out_val_next   = '0;
                                out_st_next    = 1'b0;
                            end
                            FN_COMPUTE: begin
                                nb_next    = cmd.nb;
                                clr_next   = '0;
                                state_next = ST_CLEAR;
                            end
                            FN_RD_C: begin
                                state_next = ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_READ: begin
                resp_val_next = c_live_reg ? c_q_reg : 32'd0;
                state_next    = ST_RESP;
            end
            ST_CLEAR: begin
                c_we     = 1'b1;
                c_waddr  = clr_reg;
                c_wdata  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    c_live_next = 1'b1;
                    bi_next     = '0;
                    bj_next     = '0;
                    bk_next     = '0;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    acc_next    = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mul_v_in   = 1'b1;
                state_next = ST_MULW;
            end
            ST_MULW: begin
                if (mul_v_out) begin
                    add_v_in   = 1'b1;
                    state_next = ST_ADDW;
                end
            end
            ST_ADDW: begin
                if (add_v_out) begin
                    acc_next = add_res;
                    if (k_reg == TILE_W'(TILE - 1)) begin
                        k_next     = '0;
                        state_next = ST_CRD;
                    end else begin
                        k_next     = k_reg + TILE_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_CRD: begin
                state_next = ST_CADD;
            end
            ST_CADD: begin
                add_v_in   = 1'b1;
                add_x      = c_q_reg;
                add_y      = acc_reg;
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (add_v_out) begin
                    c_we       = 1'b1;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                    j_next     = j_reg + TILE_W'(1);
                    if (j_reg == TILE_W'(TILE - 1)) begin
                        j_next = '0;
                        i_next = i_reg + TILE_W'(1);
                        if (i_reg == TILE_W'(TILE - 1)) begin
                            i_next  = '0;
                            bk_next = bk_reg + BLK_W'(1);
                            if (bk_reg == blk_last) begin
                                bk_next = '0;
                                bj_next = bj_reg + BLK_W'(1);
                                if (bj_reg == blk_last) begin
                                    bj_next = '0;
                                    bi_next = bi_reg + BLK_W'(1);
                                    if (bi_reg == blk_last) begin
                                        bi_next       = '0;
                                        resp_val_next = '0;
                                        state_next    = ST_RESP;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_val_next   = resp_val_reg;
                    out_st_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/blocked_matrix_multiply.sv]
// Blocked binary32 matrix multiply, top level.
// Items write A or B elements, start C = A*B, or read one C element; every item
// gives one result. Writes, rejected items and the response of a write are taken
// at one item per cycle while the output is not stalled; a read of C passes
// through the READ and RESP states before its result is registered. A compute
// item first sweeps all SIDE*SIDE entries of C to zero (1024 entries at the
// default size), then walks every output element of every tile product through
// one shared multiplier and adder with a dependent accumulate. The front end
// keeps taking items into a two-entry queue while the engine is busy, until the
// queue is full. After reset C reads as zero.
module blocked_matrix_multiply (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // func[1:0], row_index[6:2], col_index[11:7], element_value[43:12]
    input  logic [bmm_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_value[31:0], status[32]
    output logic [bmm_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bmm_pkg::NB_W-1:0]   cfg_data
);
    import bmm_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    bmm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bmm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    bmm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
